/* rtl/core/aftm_pkg.sv */
// Shared widths, curve constants and class codes for the filmic tone mapper.
// Used by aftm_lane, aftm_div and aces_filmic_tone_map; depends on nothing.
package aftm_pkg;

    // Port widths.
    localparam int IN_W   = 21;
    localparam int GAIN_W = 16;
    localparam int OUT_W  = 16;

    // Fixed-point formats.
    localparam int INPUT_FRAC_BITS = 12;
    localparam int OUTPUT_BITS     = 16;
    localparam int GAIN_FRAC_BITS  = 12;
    localparam int WORK_FRAC       = 16;
    localparam int PROD_FRAC       = INPUT_FRAC_BITS + GAIN_FRAC_BITS;
    localparam int CUT_SHIFT       = PROD_FRAC - WORK_FRAC;

    // Datapath widths.
    localparam int MAG_W  = IN_W - 1;
    localparam int PROD_W = MAG_W + GAIN_W;
    localparam int X_W    = 3 + WORK_FRAC;
    localparam int K_W    = 18;
    localparam int T_W    = K_W + X_W + 1;
    localparam int TH_W   = T_W - WORK_FRAC;
    localparam int PH_W   = TH_W + X_W;
    localparam int PL_W   = WORK_FRAC + X_W;
    localparam int NUM_W  = PH_W + 1;
    localparam int N_W    = NUM_W + OUTPUT_BITS + 1;

    // Register stages: six in the curve front end, one range check, one per quotient bit.
    localparam int LANE_LAT = 6 + 1 + OUTPUT_BITS;

    // Curve coefficients in Q.16.
    localparam logic [K_W-1:0] K_A = K_W'(164495);
    localparam logic [K_W-1:0] K_B = K_W'(1966);
    localparam logic [K_W-1:0] K_C = K_W'(159252);
    localparam logic [K_W-1:0] K_D = K_W'(38666);
    localparam logic [K_W-1:0] K_E = K_W'(9175);

    localparam logic [PROD_W-1:0] SAT_LIM    = PROD_W'(64'd8 << PROD_FRAC);
    localparam logic [OUT_W-1:0]  OUT_MAX    = OUT_W'((64'd1 << OUTPUT_BITS) - 64'd1);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

    // How a channel value is finished at the end of the lane.
    typedef enum logic [1:0] {
        KIND_ZERO  = 2'd0,
        KIND_SAT   = 2'd1,
        KIND_CURVE = 2'd2
    } t_kind;

endpackage

/* rtl/core/aftm_div.sv */
// Pipelined restoring divider that turns the curve ratio into a clamped UNORM code.
// One quotient bit per stage; depends on aftm_pkg.
module aftm_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [aftm_pkg::N_W-1:0]      i_dvd,
    input  logic [aftm_pkg::NUM_W-1:0]    i_den,
    input  aftm_pkg::t_kind               i_kind,
    output logic [aftm_pkg::OUTPUT_BITS-1:0] o_res
);

    localparam int OB = aftm_pkg::OUTPUT_BITS;

    logic [aftm_pkg::N_W-1:0]   r_rem  [0:OB-1];
    logic [aftm_pkg::NUM_W-1:0] r_den  [0:OB-1];
    aftm_pkg::t_kind            r_kind [0:OB];
    logic [OB-1:0]              r_q    [1:OB];
    logic                       w_over;

    // A quotient that would need more than OB bits is past full scale.
    assign w_over = i_dvd >= (aftm_pkg::N_W'(i_den) << OB);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_dvd;
            r_den[0]  <= i_den;
            r_kind[0] <= (i_kind == aftm_pkg::KIND_CURVE && w_over) ?
                         aftm_pkg::KIND_SAT : i_kind;
        end
    end

    for (genvar j = 0; j < OB; j++) begin : g_bit
        logic [aftm_pkg::N_W-1:0] w_shd;
        logic                     w_ge;

        assign w_shd = aftm_pkg::N_W'(r_den[j]) << (OB - 1 - j);
        assign w_ge  = r_rem[j] >= w_shd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_kind[j+1] <= r_kind[j];
            end
        end

        if (j < OB - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j+1] <= w_ge ? (r_rem[j] - w_shd) : r_rem[j];
                    r_den[j+1] <= r_den[j];
                end
            end
        end

        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[1] <= OB'(w_ge);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[j+1] <= {r_q[j][OB-2:0], w_ge};
                end
            end
        end
    end

    always_comb begin
        case (r_kind[OB])
            aftm_pkg::KIND_ZERO: o_res = '0;
            aftm_pkg::KIND_SAT:  o_res = '1;
            default:             o_res = r_q[OB];
        endcase
    end

endmodule

/* rtl/core/aftm_lane.sv */
// One color channel of the tone mapper: exposure scaling, curve numerator and
// denominator, then the divider. Depends on aftm_pkg and aftm_div.
module aftm_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [aftm_pkg::IN_W-1:0] i_raw,
    input  logic [aftm_pkg::GAIN_W-1:0]   i_gain,
    output logic [aftm_pkg::OUT_W-1:0]    o_res
);

    localparam int OB = aftm_pkg::OUTPUT_BITS;
    localparam int WF = aftm_pkg::WORK_FRAC;

    logic [aftm_pkg::PROD_W-1:0] r_prod;
    logic                        r_neg;
    logic [aftm_pkg::X_W-1:0]    r_x2, r_x3;
    aftm_pkg::t_kind             r_kind2, r_kind3, r_kind4, r_kind5, r_kind6;
    logic [aftm_pkg::T_W-1:0]    r_ta, r_tc;
    logic [aftm_pkg::PH_W-1:0]   r_nh, r_dh;
    logic [aftm_pkg::PL_W-1:0]   r_nl, r_dl;
    logic [aftm_pkg::NUM_W-1:0]  r_num, r_den5, r_den6;
    logic [aftm_pkg::N_W-1:0]    r_dvd;

    logic [aftm_pkg::X_W-1:0]    n_x;
    aftm_pkg::t_kind             n_kind;
    logic [aftm_pkg::OUTPUT_BITS-1:0] w_q;

    assign n_x = r_prod[aftm_pkg::CUT_SHIFT +: aftm_pkg::X_W];

    always_comb begin
        if (r_neg) begin
            n_kind = aftm_pkg::KIND_ZERO;
        end else if (r_prod >= aftm_pkg::SAT_LIM) begin
            n_kind = aftm_pkg::KIND_SAT;
        end else if (n_x == '0) begin
            n_kind = aftm_pkg::KIND_ZERO;
        end else begin
            n_kind = aftm_pkg::KIND_CURVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Scale by exposure; a negative input is handled as zero later.
            r_prod  <= aftm_pkg::PROD_W'(i_raw[aftm_pkg::MAG_W-1:0])
                     * aftm_pkg::PROD_W'(i_gain);
            r_neg   <= i_raw[aftm_pkg::IN_W-1];

            r_x2    <= n_x;
            r_kind2 <= n_kind;

            r_ta    <= aftm_pkg::T_W'(aftm_pkg::K_A) * aftm_pkg::T_W'(r_x2)
                     + (aftm_pkg::T_W'(aftm_pkg::K_B) << WF);
            r_tc    <= aftm_pkg::T_W'(aftm_pkg::K_C) * aftm_pkg::T_W'(r_x2)
                     + (aftm_pkg::T_W'(aftm_pkg::K_D) << WF);
            r_x3    <= r_x2;
            r_kind3 <= r_kind2;

            // (t * x) >> 16 split into high and low halves of t, exact.
            r_nh    <= aftm_pkg::PH_W'(r_ta[aftm_pkg::T_W-1:WF]) * aftm_pkg::PH_W'(r_x3);
            r_nl    <= aftm_pkg::PL_W'(r_ta[WF-1:0]) * aftm_pkg::PL_W'(r_x3);
            r_dh    <= aftm_pkg::PH_W'(r_tc[aftm_pkg::T_W-1:WF]) * aftm_pkg::PH_W'(r_x3);
            r_dl    <= aftm_pkg::PL_W'(r_tc[WF-1:0]) * aftm_pkg::PL_W'(r_x3);
            r_kind4 <= r_kind3;

            r_num   <= aftm_pkg::NUM_W'(r_nh) + aftm_pkg::NUM_W'(r_nl >> WF);
            r_den5  <= aftm_pkg::NUM_W'(r_dh) + aftm_pkg::NUM_W'(r_dl >> WF)
                     + (aftm_pkg::NUM_W'(aftm_pkg::K_E) << WF);
            r_kind5 <= r_kind4;

            // num * (2^OB - 1) plus half the divisor for rounding.
            r_dvd   <= (aftm_pkg::N_W'(r_num) << OB) - aftm_pkg::N_W'(r_num)
                     + aftm_pkg::N_W'(r_den5 >> 1);
            r_den6  <= r_den5;
            r_kind6 <= r_kind5;
        end
    end

    aftm_div u_div (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_dvd  (r_dvd),
        .i_den  (r_den6),
        .i_kind (r_kind6),
        .o_res  (w_q)
    );

    assign o_res = aftm_pkg::OUT_W'(w_q);

endmodule

/* rtl/core/aces_filmic_tone_map.sv */
// Top level of the ACES filmic tone mapper: exposure register, three channel
// lanes and the output register. Depends on aftm_pkg and aftm_lane.

// Maps one linear HDR pixel (three signed Q8.12 channels) per clock to UNORM16
// through the ACES filmic curve after an exposure gain (unsigned Q4.12, reset 1.0).
// Throughput is one pixel per cycle while the output is not stalled. A result passes
// six curve stages, a range check and one stage per output bit of the pipelined
// restoring divider before it is loaded into the output register, the 24th stage.
// The whole pipeline advances together and halts only while a finished pixel sits
// in the output register under stall. Write the exposure gain only while no pixel
// is in flight.
module aces_filmic_tone_map (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [aftm_pkg::IN_W-1:0] i_red_in,
    input  logic signed [aftm_pkg::IN_W-1:0] i_green_in,
    input  logic signed [aftm_pkg::IN_W-1:0] i_blue_in,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [aftm_pkg::OUT_W-1:0]       o_red_out,
    output logic [aftm_pkg::OUT_W-1:0]       o_green_out,
    output logic [aftm_pkg::OUT_W-1:0]       o_blue_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [aftm_pkg::GAIN_W-1:0]      i_cfg_data
);

    localparam int LAT = aftm_pkg::LANE_LAT;

    logic [aftm_pkg::GAIN_W-1:0] r_gain;
    logic [LAT-1:0]              r_vld;
    logic                        r_out_valid;
    logic [aftm_pkg::OUT_W-1:0]  r_red, r_green, r_blue;
    logic [aftm_pkg::OUT_W-1:0]  w_red, w_green, w_blue;
    logic                        w_adv;

    assign w_adv       = !r_out_valid || !i_stall;
    assign o_stall     = !w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= aftm_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_data;
        end
    end

    aftm_lane u_red (
        .i_clk (i_clk), .i_en (w_adv), .i_raw (i_red_in),
        .i_gain (r_gain), .o_res (w_red)
    );

    aftm_lane u_green (
        .i_clk (i_clk), .i_en (w_adv), .i_raw (i_green_in),
        .i_gain (r_gain), .o_res (w_green)
    );

    aftm_lane u_blue (
        .i_clk (i_clk), .i_en (w_adv), .i_raw (i_blue_in),
        .i_gain (r_gain), .o_res (w_blue)
    );

    // Item valid bits travel alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[LAT-2:0], i_valid};
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_red   <= w_red;
            r_green <= w_green;
            r_blue  <= w_blue;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled while output register is empty");

    a_pipe_end_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[LAT-1]) |=> o_valid)
        else $error("item leaving the lanes did not reach the output");

    a_no_phantom_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_vld[LAT-1]) |=> !o_valid)
        else $error("output valid without an item leaving the lanes");

    a_out_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red_out <= aftm_pkg::OUT_MAX && o_green_out <= aftm_pkg::OUT_MAX
                     && o_blue_out <= aftm_pkg::OUT_MAX))
        else $error("output code above full scale");

endmodule

/* verif/tb_aces_filmic_tone_map.sv */
// Self-checking testbench for aces_filmic_tone_map: directed corner pixels, then random pixels
// under several exposure gains with random gaps and stalls. Depends on aftm_pkg and the RTL.
`timescale 1ns / 1ps

module tb_aces_filmic_tone_map;

    localparam int IN_W   = aftm_pkg::IN_W;
    localparam int GAIN_W = aftm_pkg::GAIN_W;
    localparam int OUT_W  = aftm_pkg::OUT_W;

    // Curve coefficients in Q.16 and the number formats of the datapath.
    localparam longint unsigned CURVE_A   = 164495;
    localparam longint unsigned CURVE_B   = 1966;
    localparam longint unsigned CURVE_C   = 159252;
    localparam longint unsigned CURVE_D   = 38666;
    localparam longint unsigned CURVE_E   = 9175;
    localparam int              FRAC_Q16  = 16;
    localparam int              PROD_FRAC = 24;
    localparam longint unsigned UNORM_MAX = 65535;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;
    localparam logic signed [IN_W-1:0] CH_MAX = 21'sd1048575;
    localparam logic signed [IN_W-1:0] CH_MIN = -21'sd1048576;

    localparam int HANG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_mapped_pixel;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    logic signed [IN_W-1:0] i_red_in    = '0;
    logic signed [IN_W-1:0] i_green_in  = '0;
    logic signed [IN_W-1:0] i_blue_in   = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    logic [OUT_W-1:0]       o_red_out;
    logic [OUT_W-1:0]       o_green_out;
    logic [OUT_W-1:0]       o_blue_out;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [GAIN_W-1:0]      i_cfg_data  = '0;

    t_mapped_pixel     pending_pixels[$];
    logic [GAIN_W-1:0] exposure_gain = GAIN_ONE;
    bit                no_idle       = 1'b0;
    int                mismatches    = 0;
    int                pixels_sent   = 0;
    int                pixels_seen   = 0;
    int                gain_writes   = 0;
    int                stall_hold    = 0;
    int                hang_count    = 0;

    aces_filmic_tone_map DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Tone curve of one channel under the given gain, in the block's integer arithmetic.
    function automatic logic [OUT_W-1:0] tone_map_channel(logic [IN_W-1:0] raw,
                                                          logic [GAIN_W-1:0] gain);
        longint unsigned prod, x, num, den, q;
        if (raw[IN_W-1])
            return '0;
        prod = longint'(raw) * longint'(gain);
        if (prod >= (64'd8 << PROD_FRAC))
            return OUT_W'(UNORM_MAX);
        x = prod >> (PROD_FRAC - FRAC_Q16);
        if (x == 0)
            return '0;
        num = ((CURVE_A * x + (CURVE_B << FRAC_Q16)) * x) >> FRAC_Q16;
        den = (((CURVE_C * x + (CURVE_D << FRAC_Q16)) * x) >> FRAC_Q16)
              + (CURVE_E << FRAC_Q16);
        q = (num * UNORM_MAX + den / 2) / den;
        return (q > UNORM_MAX) ? OUT_W'(UNORM_MAX) : q[OUT_W-1:0];
    endfunction

    // Mostly values that land inside the curve for the current gain, plus noise.
    function automatic logic signed [IN_W-1:0] draw_channel(logic [GAIN_W-1:0] gain);
        longint unsigned target;
        longint unsigned mag;
        case ($urandom_range(0, 9))
            0: return -$signed(IN_W'($urandom_range(1, 1048576)));
            1: return IN_W'($urandom);
            2: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return -21'sd1;
                    2: return CH_MAX;
                    3: return CH_MIN;
                    default: return 21'sd1;
                endcase
            end
            default: begin
                if (gain == 0)
                    return IN_W'($urandom);
                target = $urandom_range(0, 142606336);
                mag = target / gain;
                if (mag > 1048575)
                    mag = 1048575;
                return IN_W'(mag);
            end
        endcase
    endfunction

    task automatic send_pixel(input logic signed [IN_W-1:0] red,
                              input logic signed [IN_W-1:0] green,
                              input logic signed [IN_W-1:0] blue);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_red_in   <= red;
        i_green_in <= green;
        i_blue_in  <= blue;
        do @(posedge i_clk); while (o_stall);
        pending_pixels.push_back('{red:   tone_map_channel(red, exposure_gain),
                                   green: tone_map_channel(green, exposure_gain),
                                   blue:  tone_map_channel(blue, exposure_gain)});
        pixels_sent++;
    endtask

    // The gain is only changed once every pixel in flight has come out.
    task automatic write_gain(input logic [GAIN_W-1:0] gain);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        exposure_gain = gain;
        gain_writes++;
    endtask

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                   input logic [OUT_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch on %s at pixel %0d: expected %0d, got %0d",
                     what, pixels_seen, want, got);
    endtask

    task automatic test_reset_gain();
        send_pixel('0, '0, '0);
        send_pixel(CH_MAX, CH_MIN, -21'sd1);
        send_pixel(21'sd1, 21'sd4096, 21'sd2048);
        // Exactly 8.0 saturates; just below it the curve overshoots one and is clamped.
        send_pixel(21'sd32768, 21'sd32767, 21'sd32769);
        send_pixel(21'sd255, 21'sd256, 21'sd65536);
        send_pixel(-21'sd4096, 21'sd1000, 21'sd12000);
        send_pixel(21'sd699050, 21'sd349525, 21'sd1048574);
        send_pixel(-21'sd699051, -21'sd349526, 21'sd20);
    endtask

    task automatic test_gain_extremes();
        write_gain(16'd0);
        send_pixel(CH_MAX, 21'sd4096, 21'sd1);
        send_pixel(21'sd32768, CH_MIN, 21'sd699050);
        write_gain(16'hFFFF);
        // At full gain, 2048 lands just below 8.0 and 2049 crosses it.
        send_pixel(21'sd2048, 21'sd2049, 21'sd1);
        send_pixel(21'sd100, CH_MAX, -21'sd1);
        write_gain(16'd1);
        send_pixel(21'sd255, 21'sd256, CH_MAX);
        send_pixel(21'sd699050, 21'sd349525, 21'sd65536);
        write_gain(GAIN_ONE);
        send_pixel(21'sd8192, 21'sd409, 21'sd2);
    endtask

    task automatic test_random_pixels();
        logic [GAIN_W-1:0] gain;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: gain = 16'hFFFF;
                1: gain = 16'd1;
                2: gain = 16'd2048;
                3: gain = 16'd12288;
                default: gain = GAIN_W'($urandom);
            endcase
            write_gain(gain);
            no_idle = (phase == 2) || (phase == 5);
            for (int n = 0; n < 135; n++)
                send_pixel(draw_channel(exposure_gain), draw_channel(exposure_gain),
                           draw_channel(exposure_gain));
            no_idle = 1'b0;
        end
    endtask

    // Receiver back-pressure: a fresh stall length after each accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_hold = 0;
        end else if (o_valid && !i_stall) begin
            stall_hold = no_idle ? 0 : $urandom_range(0, 4);
            i_stall    <= (stall_hold > 0);
        end else if (stall_hold > 0) begin
            stall_hold = stall_hold - 1;
            i_stall    <= (stall_hold > 0);
        end
    end

    always @(posedge i_clk) begin
        t_mapped_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: %0d %0d %0d",
                             o_red_out, o_green_out, o_blue_out);
            end else begin
                want = pending_pixels.pop_front();
                if (o_red_out !== want.red)
                    report_mismatch("red", want.red, o_red_out);
                if (o_green_out !== want.green)
                    report_mismatch("green", want.green, o_green_out);
                if (o_blue_out !== want.blue)
                    report_mismatch("blue", want.blue, o_blue_out);
            end
            pixels_seen++;
        end
    end

    // Ends a hung run: counts cycles in which no channel completes a handshake.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            hang_count = 0;
        end else begin
            hang_count++;
            if (hang_count >= HANG_LIMIT) begin
                $display("Timeout after %0d idle cycles", HANG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_gain();
        test_gain_extremes();
        test_random_pixels();

        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", pending_pixels.size());
        end

        $display("Sent %0d pixels under %0d gain writes, including zero and full-scale gain.",
                 pixels_sent, gain_writes);
        $display("Checked %0d results; %0d mismatches.", pixels_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
